// ----- hdl/srg_pkg.sv -----
package srg_pkg;

  // Field and datapath widths
  localparam int POS_W     = 32;
  localparam int DIFF_W    = 33;
  localparam int VEL_W     = 40;
  localparam int ACC_W     = 41;
  localparam int WIDE_W    = 60;
  localparam int MUL_W     = 40;
  localparam int DIV_NW    = 80;
  localparam int DIV_DW    = 51;
  localparam int PERIOD_W  = 20;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX  = '1;
  localparam logic [TIME_W-1:0]   ARRIVE_TIME = 32'd10000;

  typedef enum logic [1:0] {
    ACT_MOVE  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_LIMIT = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_BRAKE = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE       = 3'd0,
    CFG_SPEED_MIN    = 3'd1,
    CFG_SPEED_MAX    = 3'd2,
    CFG_ACCEL_NORMAL = 3'd3,
    CFG_ACCEL_LIMIT  = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOVE,
    ST_MOVE_DIV,
    ST_TICK,
    ST_SQ_MUL,
    ST_SQ_DIV,
    ST_VEL,
    ST_VEL_DIV,
    ST_VEL_FIX,
    ST_PER,
    ST_PER_DIV,
    ST_DONE
  } state_t;

endpackage

// ----- hdl/srg_multiplier.sv -----
module srg_multiplier (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [srg_pkg::MUL_W-1:0]           operand,
  output logic                                done,
  output logic [2*srg_pkg::MUL_W-1:0]         product
);
  import srg_pkg::*;

  localparam int CNT_W = $clog2(MUL_W);

  logic                 running;
  logic [CNT_W-1:0]     cnt;
  logic [2*MUL_W-1:0]   mcand;
  logic [MUL_W-1:0]     mplier;

  // Shift-add squaring, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        product <= '0;
        mcand   <= (2*MUL_W)'(operand);
        mplier  <= operand;
      end else if (running) begin
        if (mplier[0]) begin
          product <= product + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(MUL_W-1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/srg_divider.sv -----
module srg_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [srg_pkg::DIV_NW-1:0]    num,
  input  logic [srg_pkg::DIV_DW-1:0]    den,
  output logic                          done,
  output logic [srg_pkg::DIV_NW:0]      quo
);
  import srg_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW);

  logic                 running;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DW-1:0]    den_r;
  logic [DIV_DW-1:0]    rem;
  logic [DIV_NW-1:0]    q;
  logic [DIV_DW:0]      trial;
  logic                 fits;
  logic                 round_up;

  // Restoring division, one quotient bit per cycle
  assign trial = {rem, q[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  // Round to nearest, halves away from zero
  assign round_up = {rem, 1'b0} >= {1'b0, den_r};
  assign quo      = {1'b0, q} + (DIV_NW+1)'(round_up);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        q       <= num;
        den_r   <= den;
      end else if (running) begin
        rem <= fits ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
        q   <= {q[DIV_NW-2:0], fits};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_NW-1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/stepper_ramp_generator_unit.sv -----
// Stepper trapezoidal ramp generator.
// Input channel (in_valid/in_ready) carries one action per item: a move
// command with its target, a step timer tick, or a limit switch hit. Each
// item gives exactly one result item on the output channel
// (out_valid/out_ready): step pulse, direction, next timer period, timer
// start flag, arrival flag, position and accumulated time.
// Items are handled one at a time. A limit hit, an ignored item or an
// arrival uses no arithmetic unit; a move start makes at most one pass
// through the restoring divider; a tick may use the shift-add squarer
// and up to three divider passes (braking estimate, velocity step, period).
// Results sit in an output register: in_ready returns as soon as the
// result is loaded, while it still waits for out_ready. If the receiver
// stalls with a result pending, the next result holds in the sequencer
// until the output register frees up.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once. The
// user must make them only while the block is idle; it does not enforce this.
// Reset (rst, synchronous) clears position, target, velocity, time and the
// motion mode, and loads the default configuration; no items are pending.
module stepper_ramp_generator_unit #(
  parameter int TICK_HZ   = 1000000,
  parameter int FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [srg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srg_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         action,
  input  logic signed [srg_pkg::POS_W-1:0]   target_position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               step_pulse,
  output logic                               direction,
  output logic [srg_pkg::PERIOD_W-1:0]       period_us,
  output logic                               timer_run,
  output logic                               arrived,
  output logic signed [srg_pkg::POS_W-1:0]   position,
  output logic [srg_pkg::TIME_W-1:0]         elapsed_time
);
  import srg_pkg::*;

  // Configuration
  logic                enable;
  logic [16:0]         speed_min;
  logic [19:0]         speed_max;
  logic [19:0]         accel_normal;
  logic [23:0]         accel_limit;

  // Motion state
  state_t              state, state_next;
  mode_t               mode;
  logic [POS_W-1:0]    cur_position;
  logic [POS_W-1:0]    goal_position;
  logic signed [VEL_W-1:0] velocity;
  logic                dir_pin;
  logic [TIME_W-1:0]   time_count;

  // Per-item scratch
  logic [ACC_W-1:0]    acc_mag;
  logic                acc_neg;
  logic                vel_brake;
  logic                res_step, res_run, res_arrived;
  logic [PERIOD_W-1:0] res_period;

  // Shared units
  logic                div_start, div_done;
  logic [DIV_NW-1:0]   div_num;
  logic [DIV_DW-1:0]   div_den;
  logic [DIV_NW:0]     div_quo;
  logic                mul_start, mul_done;
  logic [2*MUL_W-1:0]  mul_prod;

  logic                in_fire, out_load, move_start;

  // Derived values
  logic [DIFF_W-1:0]       diff, diff_abs;
  logic                    s_pos, s_neg, v_pos, v_neg;
  logic [VEL_W-1:0]        vel_abs;
  logic signed [WIDE_W-1:0] vel_x, div_val, den_vel, q_w, delta, vel_sum, vel_new;
  logic signed [WIDE_W-1:0] vel_hi, vel_lo;
  logic [WIDE_W-1:0]       smin_q, acc_n, acc_l, lim;
  logic                    vel_lt_smin, tick_arrive, tick_rev, tick_sq, acc_le;
  logic [ACC_W-1:0]        rev_mag, sq_mag;
  logic [PERIOD_W-1:0]     per_q, per_val;
  logic                    per_finish;

  assign in_fire = in_valid && in_ready;
  assign move_start = enable && (mode == MODE_IDLE) &&
                      (POS_W'(target_position) != cur_position);

  assign smin_q = WIDE_W'(speed_min) << FRAC_BITS;
  assign acc_n  = WIDE_W'(accel_normal) << FRAC_BITS;
  assign acc_l  = WIDE_W'(accel_limit) << FRAC_BITS;
  assign lim    = WIDE_W'(speed_max) << FRAC_BITS;
  assign vel_hi = $signed({{(WIDE_W-VEL_W+1){1'b0}}, {(VEL_W-1){1'b1}}});
  assign vel_lo = ~vel_hi;

  // Distance to target, exact (no wrap)
  assign diff     = {goal_position[POS_W-1], goal_position} -
                    {cur_position[POS_W-1], cur_position};
  assign diff_abs = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
  assign s_neg    = diff[DIFF_W-1];
  assign s_pos    = !diff[DIFF_W-1] && (diff != '0);

  assign vel_x   = {{(WIDE_W-VEL_W){velocity[VEL_W-1]}}, velocity};
  assign vel_abs = velocity[VEL_W-1] ? (~VEL_W'(velocity) + VEL_W'(1)) : VEL_W'(velocity);
  assign v_neg   = velocity[VEL_W-1];
  assign v_pos   = !velocity[VEL_W-1] && (velocity != '0);

  // Tick decisions
  assign vel_lt_smin = WIDE_W'(vel_abs) < smin_q;
  assign tick_arrive = (diff == '0) && vel_lt_smin;
  assign tick_rev    = (diff != '0) && (vel_x >= $signed(smin_q)) &&
                       ({s_pos, s_neg} != {v_pos, v_neg});
  assign tick_sq     = !tick_rev && (diff != '0) && (velocity != '0);
  assign rev_mag     = (WIDE_W'(vel_abs) < acc_n) ? ACC_W'(vel_abs) : ACC_W'(acc_n);
  assign sq_mag      = (div_quo > (DIV_NW+1)'(acc_l)) ? ACC_W'(acc_l) : ACC_W'(div_quo);
  assign acc_le      = WIDE_W'(acc_mag) <= acc_n;

  // Velocity update divisor
  assign div_val = (vel_x > $signed(smin_q)) ? vel_x : $signed(smin_q);
  assign den_vel = (div_val <= 0) ? WIDE_W'(1) : div_val;

  // Velocity update
  assign q_w = $signed(WIDE_W'(div_quo));
  always_comb begin
    if (vel_brake) begin
      delta = acc_neg ? -q_w : q_w;
    end else if (s_pos) begin
      delta = q_w;
    end else if (s_neg) begin
      delta = -q_w;
    end else begin
      delta = '0;
    end
  end
  assign vel_sum = vel_x + delta;
  always_comb begin
    if (vel_brake) begin
      if (vel_sum > vel_hi) vel_new = vel_hi;
      else if (vel_sum < vel_lo) vel_new = vel_lo;
      else vel_new = vel_sum;
    end else begin
      if (vel_sum > $signed(lim)) vel_new = $signed(lim);
      else if (vel_sum < -$signed(lim)) vel_new = -$signed(lim);
      else vel_new = vel_sum;
    end
  end

  // Period saturation
  assign per_q      = (div_quo > (DIV_NW+1)'(PERIOD_MAX)) ? PERIOD_MAX :
                      div_quo[PERIOD_W-1:0];
  assign per_val    = (vel_abs == '0) ? PERIOD_MAX : per_q;
  assign per_finish = ((state == ST_PER) && (vel_abs == '0)) ||
                      ((state == ST_PER_DIV) && div_done);

  // Divider operand select
  always_comb begin
    case (state)
      ST_MOVE: begin
        div_num = DIV_NW'(TICK_HZ);
        div_den = DIV_DW'(speed_min);
      end
      ST_SQ_MUL: begin
        div_num = mul_prod;
        div_den = DIV_DW'(diff_abs) << (FRAC_BITS + 1);
      end
      ST_VEL: begin
        div_num = acc_le ? (DIV_NW'(accel_normal) << (2*FRAC_BITS)) :
                           (DIV_NW'(acc_mag) << FRAC_BITS);
        div_den = DIV_DW'(den_vel);
      end
      ST_PER: begin
        div_num = DIV_NW'(TICK_HZ) << FRAC_BITS;
        div_den = DIV_DW'(vel_abs);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (action == ACT_MOVE && move_start) state_next = ST_MOVE;
          else if (action == ACT_TICK && mode != MODE_IDLE) state_next = ST_TICK;
          else state_next = ST_DONE;
        end
      end
      ST_MOVE:     state_next = (speed_min != '0) ? ST_MOVE_DIV : ST_DONE;
      ST_MOVE_DIV: if (div_done) state_next = ST_DONE;
      ST_TICK: begin
        if (tick_arrive) state_next = ST_DONE;
        else if (tick_sq) state_next = ST_SQ_MUL;
        else state_next = ST_VEL;
      end
      ST_SQ_MUL:   if (mul_done) state_next = ST_SQ_DIV;
      ST_SQ_DIV:   if (div_done) state_next = ST_VEL;
      ST_VEL:      state_next = div_start ? ST_VEL_DIV : ST_VEL_FIX;
      ST_VEL_DIV:  if (div_done) state_next = ST_VEL_FIX;
      ST_VEL_FIX:  state_next = ST_PER;
      ST_PER:      state_next = (vel_abs != '0) ? ST_PER_DIV : ST_DONE;
      ST_PER_DIV:  if (div_done) state_next = ST_DONE;
      ST_DONE:     if (!out_valid || out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE:   in_ready  = 1'b1;
      ST_MOVE:   div_start = (speed_min != '0);
      ST_TICK:   mul_start = !tick_arrive && tick_sq;
      ST_SQ_MUL: div_start = mul_done;
      ST_VEL:    div_start = acc_le ? (mode == MODE_RUN) : 1'b1;
      ST_PER:    div_start = (vel_abs != '0);
      ST_DONE:   out_load  = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Motion state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      speed_min     <= 17'd100;
      speed_max     <= 20'd1000;
      accel_normal  <= 20'd1000;
      accel_limit   <= 24'd5000;
      mode          <= MODE_IDLE;
      cur_position  <= '0;
      goal_position <= '0;
      velocity      <= '0;
      dir_pin       <= 1'b0;
      time_count    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:       enable       <= cfg_data[0];
          CFG_SPEED_MIN:    speed_min    <= cfg_data[16:0];
          CFG_SPEED_MAX:    speed_max    <= cfg_data[19:0];
          CFG_ACCEL_NORMAL: accel_normal <= cfg_data[19:0];
          CFG_ACCEL_LIMIT:  accel_limit  <= cfg_data[23:0];
          default: begin
          end
        endcase
      end

      // Item entry
      if (in_fire) begin
        if (action == ACT_MOVE) begin
          goal_position <= POS_W'(target_position);
          if (move_start) begin
            dir_pin <= target_position >= $signed(cur_position);
            mode    <= MODE_RUN;
          end
        end else if (action == ACT_LIMIT) begin
          cur_position  <= '0;
          goal_position <= '0;
        end else if (action == ACT_TICK && mode != MODE_IDLE) begin
          cur_position <= dir_pin ? cur_position + POS_W'(1) : cur_position - POS_W'(1);
        end
      end

      // Arrival or reverse
      if (state == ST_TICK) begin
        if (tick_arrive) begin
          mode       <= MODE_IDLE;
          velocity   <= '0;
          time_count <= time_count + ARRIVE_TIME;
        end else if (tick_rev) begin
          mode <= MODE_RUN;
        end
      end

      if (state == ST_VEL && !acc_le) mode <= MODE_BRAKE;
      if (state == ST_VEL_DIV && div_done) velocity <= VEL_W'(vel_new);

      // Floor at minimum speed
      if (state == ST_VEL_FIX && vel_lt_smin) begin
        if (s_pos) velocity <= smin_q[VEL_W-1:0];
        else if (s_neg) velocity <= -$signed(smin_q[VEL_W-1:0]);
        else velocity <= '0;
      end

      if (per_finish) begin
        dir_pin    <= !velocity[VEL_W-1];
        time_count <= time_count + TIME_W'(per_val);
      end
    end
  end

  // Per-item scratch and result fields
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_step    <= (action == ACT_TICK) && (mode != MODE_IDLE);
      res_run     <= (action == ACT_MOVE) && move_start;
      res_arrived <= 1'b0;
      res_period  <= '0;
    end
    if (state == ST_MOVE && speed_min == '0) res_period <= PERIOD_MAX;
    if (state == ST_MOVE_DIV && div_done) res_period <= per_q;
    if (state == ST_TICK) begin
      res_arrived <= tick_arrive;
      acc_neg     <= s_neg;
      acc_mag     <= tick_rev ? rev_mag : '0;
    end
    if (state == ST_SQ_DIV && div_done) begin
      acc_mag <= sq_mag;
      acc_neg <= s_pos;
    end
    if (state == ST_VEL) vel_brake <= !acc_le;
    if (per_finish) begin
      res_period <= per_val;
      res_run    <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      step_pulse   <= res_step;
      direction    <= dir_pin;
      period_us    <= res_period;
      timer_run    <= res_run;
      arrived      <= res_arrived;
      position     <= $signed(cur_position);
      elapsed_time <= time_count;
    end
  end

  srg_multiplier u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .operand (vel_abs),
    .done    (mul_done),
    .product (mul_prod)
  );

  srg_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Checks
  a_arrive_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && arrived |-> step_pulse && !timer_run && period_us == '0)
    else $error("arrival result starts the timer");

  a_idle_period: assert property (@(posedge clk) disable iff (rst)
    out_valid && !timer_run |-> period_us == '0)
    else $error("period given without timer start");

  a_idle_still: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_IDLE |-> velocity == '0)
    else $error("velocity nonzero while idle");

  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_valid && !out_ready |=> state == ST_DONE)
    else $error("result dropped during stall");

endmodule
